FILE: src/lkv_pkg.sv
// Shared constants and types for the LRU key/value cache.
`timescale 1ns / 1ps

package lkv_pkg;

  localparam int DEPTH_DEF     = 16;
  localparam int KEY_WIDTH_DEF = 32;

  localparam int          CAP_W     = 5;
  localparam logic [4:0]  CAP_RESET = 5'd16;

  localparam int          FIELD_W   = 32;

  // Request kinds
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  localparam logic [31:0] MISS_VALUE = 32'hFFFF_FFFF;

  // Broadcast from the control logic to every entry cell
  typedef struct packed {
    logic upd;      // commit a state change this cycle
    logic inc_all;  // fill of a free slot: every valid entry ages by one
    logic wr_val;   // target slot takes the incoming value
  } lkv_ctl_t;

endpackage

FILE: src/lkv_entry.sv
// One cache entry: key/value storage, valid bit, age rank and its update.
`timescale 1ns / 1ps

module lkv_entry #(
  parameter int KEY_WIDTH = lkv_pkg::KEY_WIDTH_DEF,
  parameter int RANK_W    = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lkv_pkg::lkv_ctl_t    ctl_i,
  input  logic                 tgt_i,        // this entry is the one written/promoted
  input  logic [KEY_WIDTH-1:0] key_i,
  input  logic [31:0]          value_i,
  input  logic [RANK_W-1:0]    thr_i,        // entries younger than this age by one
  input  logic [RANK_W-1:0]    last_rank_i,  // rank of the oldest entry now
  input  logic [RANK_W-1:0]    last_nxt_i,   // rank of the oldest entry after the update
  output logic                 match_o,
  output logic                 is_old_o,
  output logic [RANK_W-1:0]    rank_o,
  output logic [31:0]          value_o,
  output logic [KEY_WIDTH-1:0] key_nxt_o,
  output logic                 newest_nxt_o,
  output logic                 oldest_nxt_o
);

  logic                 valid_r, valid_nxt;
  logic [RANK_W-1:0]    rank_r, rank_nxt;
  logic [KEY_WIDTH-1:0] key_r, key_nxt;
  logic [31:0]          value_r, value_nxt;
  logic                 wr;

  assign wr = ctl_i.upd & tgt_i;

  always_comb begin
    valid_nxt = valid_r | wr;
    key_nxt   = wr ? key_i : key_r;
    value_nxt = (wr && ctl_i.wr_val) ? value_i : value_r;
    rank_nxt  = rank_r;
    if (ctl_i.upd) begin
      if (tgt_i) begin
        rank_nxt = '0;
      end else if (valid_r && (ctl_i.inc_all || rank_r < thr_i)) begin
        rank_nxt = rank_r + RANK_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      rank_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      rank_r  <= rank_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    value_r <= value_nxt;
  end

  assign match_o      = valid_r && (key_r == key_i);
  assign is_old_o     = valid_r && (rank_r == last_rank_i);
  assign rank_o       = rank_r;
  assign value_o      = value_r;
  assign key_nxt_o    = key_nxt;
  assign newest_nxt_o = valid_nxt && (rank_nxt == '0);
  assign oldest_nxt_o = valid_nxt && (rank_nxt == last_nxt_i);

endmodule

FILE: src/lru_key_value_cache_unit.sv
// Top level of the fully associative LRU key/value cache.
`timescale 1ns / 1ps

// Fully associative key/value cache of DEPTH entries with least-recently-used
// replacement. Each input beat is an insert (kind 0) or a lookup (kind 1) of a
// key; every beat gives exactly one result beat with hit, read value (-1 on a
// lookup miss, the written value on an insert), and the newest and oldest keys
// plus a not-empty flag as they stand after the beat. Keys are compared on
// their low KEY_WIDTH bits. An item is taken into an input register, all key
// compares, the age-rank update and the result are worked out combinationally,
// and the result lands in an output register: one beat per cycle sustained
// while out_stall is low; a stalled result holds the item in the input register
// and raises in_stall. The rate is set by the combinational CAM compare and
// rank update feeding the entry registers. Entries fill slots in order, so
// slot occ is always the next free
// one; each entry holds a rank, 0 for most recent up to occupancy-1 for the
// oldest. The capacity register (reset 16; 0 acts as 1, values above DEPTH
// act as DEPTH) is meant to be written while the block is idle; cfg_ready is
// always high. No clearing pass is needed after reset.

module lru_key_value_cache_unit #(
  parameter int DEPTH     = lkv_pkg::DEPTH_DEF,
  parameter int KEY_WIDTH = lkv_pkg::KEY_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // request channel
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_kind,
  input  logic [31:0]                in_key,
  input  logic signed [31:0]         in_value,
  // result channel
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_hit,
  output logic signed [31:0]         out_read_value,
  output logic                       out_not_empty,
  output logic [31:0]                out_newest_key,
  output logic [31:0]                out_oldest_key,
  // capacity register write
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [lkv_pkg::CAP_W-1:0]  cfg_data
);

  localparam int RANK_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OCC_W  = $clog2(DEPTH + 1);
  localparam int CMP_W  = (OCC_W > lkv_pkg::CAP_W) ? OCC_W : lkv_pkg::CAP_W;

  // ---------------------------------------------------------------------
  // Capacity register
  // ---------------------------------------------------------------------
  logic [lkv_pkg::CAP_W-1:0] cap_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= lkv_pkg::CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      cap_r <= cfg_data;
    end
  end

  // ---------------------------------------------------------------------
  // Input register and beat flow
  // ---------------------------------------------------------------------
  logic        in_vld_r;
  logic        kind_r;
  logic [31:0] key_r;
  logic [31:0] val_r;
  logic        out_vld_r;
  logic        advance;
  logic        in_acc;

  assign in_stall = in_vld_r && out_vld_r && out_stall;
  assign in_acc   = in_valid && !in_stall;
  assign advance  = in_vld_r && !(out_vld_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_acc) begin
      in_vld_r <= 1'b1;
    end else if (advance) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      kind_r <= in_kind;
      key_r  <= in_key;
      val_r  <= in_value;
    end
  end

  // ---------------------------------------------------------------------
  // Occupancy and replacement decision
  // ---------------------------------------------------------------------
  logic [OCC_W-1:0]     occ_r, occ_nxt, occ_m1, occ_nxt_m1;
  logic [63:0]          key_ext;
  logic [KEY_WIDTH-1:0] key_cmp;
  logic                 is_lookup;
  logic                 hit;
  logic                 use_free;
  logic [RANK_W-1:0]    hit_rank;
  logic [31:0]          hit_value;
  logic [RANK_W-1:0]    thr;
  lkv_pkg::lkv_ctl_t    ctl;

  logic [DEPTH-1:0]     match_w, old_w, free_w, tgt_w, newest_w, oldest_w;
  logic [RANK_W-1:0]    rank_w    [DEPTH];
  logic [31:0]          value_w   [DEPTH];
  logic [KEY_WIDTH-1:0] key_nxt_w [DEPTH];

  assign key_ext   = {32'd0, key_r};
  assign key_cmp   = key_ext[KEY_WIDTH-1:0];
  assign is_lookup = (kind_r == lkv_pkg::KIND_LOOKUP);
  assign hit       = |match_w;

  // Room left below the effective capacity (0 behaves as 1, clipped at DEPTH)
  always_comb begin
    if (cap_r == '0) begin
      use_free = (occ_r == '0);
    end else begin
      use_free = (CMP_W'(occ_r) < CMP_W'(cap_r)) && (CMP_W'(occ_r) < CMP_W'(DEPTH));
    end
  end

  // Keys are unique, so the OR over the matching entry is its rank/value
  always_comb begin
    hit_rank  = '0;
    hit_value = '0;
    for (int i = 0; i < DEPTH; i++) begin
      hit_rank  = hit_rank  | (rank_w[i]  & {RANK_W{match_w[i]}});
      hit_value = hit_value | (value_w[i] & {32{match_w[i]}});
    end
  end

  assign occ_m1 = occ_r - OCC_W'(1);

  always_comb begin
    ctl.upd     = advance && (!is_lookup || hit);
    ctl.inc_all = !hit && use_free;
    ctl.wr_val  = !is_lookup;
    // on eviction the victim holds the top rank, so everything else ages
    thr         = hit ? hit_rank : occ_m1[RANK_W-1:0];
    occ_nxt     = occ_r;
    if (!is_lookup && !hit && use_free) begin
      occ_nxt = occ_r + OCC_W'(1);
    end
  end

  assign occ_nxt_m1 = occ_nxt - OCC_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else if (advance) begin
      occ_r <= occ_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Entry array
  // ---------------------------------------------------------------------
  for (genvar g = 0; g < DEPTH; g++) begin : g_entry
    // slots fill in order, so the next free one is slot occ
    assign free_w[g] = (occ_r == OCC_W'(g));
    assign tgt_w[g]  = hit ? match_w[g] : (use_free ? free_w[g] : old_w[g]);

    lkv_entry #(
      .KEY_WIDTH (KEY_WIDTH),
      .RANK_W    (RANK_W)
    ) u_entry (
      .clk          (clk),
      .rst_n        (rst_n),
      .ctl_i        (ctl),
      .tgt_i        (tgt_w[g]),
      .key_i        (key_cmp),
      .value_i      (val_r),
      .thr_i        (thr),
      .last_rank_i  (occ_m1[RANK_W-1:0]),
      .last_nxt_i   (occ_nxt_m1[RANK_W-1:0]),
      .match_o      (match_w[g]),
      .is_old_o     (old_w[g]),
      .rank_o       (rank_w[g]),
      .value_o      (value_w[g]),
      .key_nxt_o    (key_nxt_w[g]),
      .newest_nxt_o (newest_w[g]),
      .oldest_nxt_o (oldest_w[g])
    );
  end

  // ---------------------------------------------------------------------
  // Result formation and output register
  // ---------------------------------------------------------------------
  logic [31:0] newest_key, oldest_key, read_value;
  logic [63:0] ext;

  always_comb begin
    newest_key = '0;
    oldest_key = '0;
    ext        = '0;
    for (int i = 0; i < DEPTH; i++) begin
      ext                  = '0;
      ext[KEY_WIDTH-1:0]   = key_nxt_w[i];
      newest_key = newest_key | (ext[31:0] & {32{newest_w[i]}});
      oldest_key = oldest_key | (ext[31:0] & {32{oldest_w[i]}});
    end
  end

  always_comb begin
    if (!is_lookup) begin
      read_value = val_r;
    end else if (hit) begin
      read_value = hit_value;
    end else begin
      read_value = lkv_pkg::MISS_VALUE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  logic        hit_out_r, not_empty_r;
  logic [31:0] read_value_r, newest_r, oldest_r;

  always_ff @(posedge clk) begin
    if (advance) begin
      hit_out_r    <= hit;
      read_value_r <= read_value;
      not_empty_r  <= (occ_nxt != '0);
      newest_r     <= newest_key;
      oldest_r     <= oldest_key;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_hit        = hit_out_r;
  assign out_read_value = read_value_r;
  assign out_not_empty  = not_empty_r;
  assign out_newest_key = newest_r;
  assign out_oldest_key = oldest_r;

endmodule

FILE: tb/lru_key_value_cache_unit_tb.sv
// Self-checking testbench for the LRU key/value cache: predictor, driver, monitor.
`timescale 1ns / 1ps

module lru_key_value_cache_unit_tb;

  localparam int SLOTS       = lkv_pkg::DEPTH_DEF;
  localparam int CAP_BITS    = lkv_pkg::CAP_W;
  localparam int QUIET_LIMIT = 1000;   // cycles with no beat on any channel

  typedef struct {
    logic               kind;
    logic [31:0]        key;
    logic signed [31:0] value;
  } cache_request_t;

  typedef struct {
    logic               hit;
    logic signed [31:0] read_value;
    logic               not_empty;
    logic [31:0]        newest_key;
    logic [31:0]        oldest_key;
  } cache_result_t;

  logic clk;
  logic rst_n = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_kind  = lkv_pkg::KIND_INSERT;
  logic [31:0]        in_key   = '0;
  logic signed [31:0] in_value = '0;

  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_hit;
  logic signed [31:0] out_read_value;
  logic               out_not_empty;
  logic [31:0]        out_newest_key;
  logic [31:0]        out_oldest_key;

  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CAP_BITS-1:0] cfg_data  = '0;

  lru_key_value_cache_unit i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_key         (in_key),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hit        (out_hit),
    .out_read_value (out_read_value),
    .out_not_empty  (out_not_empty),
    .out_newest_key (out_newest_key),
    .out_oldest_key (out_oldest_key),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  // 12 ns period
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: our own copy of the cache contents and recency ranks.
  // Rank 0 is the most recent valid entry, fill_count-1 the oldest.
  // ---------------------------------------------------------------------------
  logic [31:0]         slot_key  [SLOTS];
  logic [31:0]         slot_val  [SLOTS];
  bit                  slot_used [SLOTS];
  int                  slot_rank [SLOTS];
  int                  fill_count;
  logic [CAP_BITS-1:0] cap_reg = lkv_pkg::CAP_RESET;

  cache_request_t pending_q[$];     // requests waiting for the driver
  cache_result_t  owed_results[$];  // predicted results, oldest first

  // handshake flags, registered at the rising edge so the falling-edge
  // processes see a settled view of the last edge
  logic in_beat  = 1'b0;
  logic out_beat = 1'b0;
  logic cfg_beat = 1'b0;
  int   results_owed = 0;

  int errors      = 0;
  int quiet_count = 0;
  int n_requests  = 0;
  int n_lookups   = 0;
  int n_hits      = 0;
  int n_evictions = 0;
  int n_cap_writes = 0;

  // Valid entry with the highest rank, lowest index wins a tie; -1 if empty.
  function automatic int oldest_slot();
    int best;
    best = -1;
    for (int i = 0; i < SLOTS; i++)
      if (slot_used[i] && (best < 0 || slot_rank[i] > slot_rank[best]))
        best = i;
    return best;
  endfunction

  // Move a hit entry to the front; only entries younger than it age.
  function automatic void promote_slot(int s);
    int r;
    r = slot_rank[s];
    for (int i = 0; i < SLOTS; i++)
      if (slot_used[i] && slot_rank[i] < r)
        slot_rank[i]++;
    slot_rank[s] = 0;
  endfunction

  // Apply one request to the predictor state and return the result beat.
  function automatic cache_result_t apply_request(cache_request_t req);
    cache_result_t res;
    int eff_cap, hit_slot, fill_slot, newest, oldest;
    // capacity 0 behaves as 1, anything above the array size saturates
    eff_cap = (cap_reg == 0) ? 1 : (int'(cap_reg) > SLOTS) ? SLOTS : int'(cap_reg);
    hit_slot = -1;
    for (int i = 0; i < SLOTS; i++)
      if (slot_used[i] && slot_key[i] == req.key && hit_slot < 0)
        hit_slot = i;
    res.hit = (hit_slot >= 0);
    n_requests++;

    if (req.kind == lkv_pkg::KIND_LOOKUP) begin
      n_lookups++;
      if (hit_slot >= 0) begin
        n_hits++;
        promote_slot(hit_slot);
        res.read_value = slot_val[hit_slot];
      end else begin
        res.read_value = lkv_pkg::MISS_VALUE;   // miss leaves the state alone
      end
    end else begin
      res.read_value = req.value;
      if (hit_slot >= 0) begin
        slot_val[hit_slot] = req.value;
        promote_slot(hit_slot);
      end else begin
        fill_slot = -1;
        if (fill_count < eff_cap) begin
          for (int i = 0; i < SLOTS; i++)
            if (!slot_used[i] && fill_slot < 0)
              fill_slot = i;
          if (fill_slot >= 0)
            fill_count++;
        end
        // full, or capacity lowered under the fill level: replace the oldest
        if (fill_slot < 0) begin
          fill_slot = oldest_slot();
          if (fill_slot >= 0) begin
            slot_used[fill_slot] = 1'b0;
            n_evictions++;
          end
        end
        if (fill_slot >= 0) begin
          for (int i = 0; i < SLOTS; i++)
            if (slot_used[i])
              slot_rank[i]++;
          slot_used[fill_slot] = 1'b1;
          slot_key[fill_slot]  = req.key;
          slot_val[fill_slot]  = req.value;
          slot_rank[fill_slot] = 0;
        end
      end
    end

    newest = -1;
    for (int i = 0; i < SLOTS; i++)
      if (slot_used[i] && slot_rank[i] == 0 && newest < 0)
        newest = i;
    oldest = oldest_slot();
    res.not_empty  = (fill_count != 0);
    res.newest_key = (newest >= 0) ? slot_key[newest] : '0;
    res.oldest_key = (oldest >= 0) ? slot_key[oldest] : '0;
    return res;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: samples all three channels at the rising edge, feeds accepted
  // requests to the predictor and checks each result beat against the oldest
  // prediction. Also runs the watchdog.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    cache_result_t want;
    in_beat  <= rst_n && in_valid && !in_stall;
    out_beat <= rst_n && out_valid && !out_stall;
    cfg_beat <= rst_n && cfg_valid && cfg_ready;

    if (rst_n && out_valid && !out_stall) begin
      if (owed_results.size() == 0) begin
        $error("result beat with no request outstanding");
        errors++;
      end else begin
        want = owed_results.pop_front();
        check_field("hit",        32'(want.hit),       32'(out_hit));
        check_field("read_value", want.read_value,     out_read_value);
        check_field("not_empty",  32'(want.not_empty), 32'(out_not_empty));
        check_field("newest_key", want.newest_key,     out_newest_key);
        check_field("oldest_key", want.oldest_key,     out_oldest_key);
      end
    end

    if (rst_n && cfg_valid && cfg_ready) begin
      cap_reg = cfg_data;
      n_cap_writes++;
    end

    if (rst_n && in_valid && !in_stall)
      owed_results.push_back(apply_request(cache_request_t'{in_kind, in_key, in_value}));

    results_owed <= owed_results.size();

    if ((rst_n && in_valid && !in_stall) || (rst_n && out_valid && !out_stall) ||
        (rst_n && cfg_valid && cfg_ready)) begin
      quiet_count <= 0;
    end else if (quiet_count + 1 >= QUIET_LIMIT) begin
      $display("Watchdog: no beat for %0d cycles, %0d results outstanding",
               QUIET_LIMIT, owed_results.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_count <= quiet_count + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Request driver: falling edge. A presented beat holds until taken; after
  // each beat a random gap, with calm stretches of no gaps.
  // ---------------------------------------------------------------------------
  int unsigned gap_left = 0;
  bit          drv_calm = 1'b0;

  always @(negedge clk) begin : request_driver
    cache_request_t req;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else if (!in_valid || in_beat) begin
      if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_q.size() != 0) begin
        req = pending_q.pop_front();
        in_kind  <= req.kind;
        in_key   <= req.key;
        in_value <= req.value;
        in_valid <= 1'b1;
        if ($urandom_range(0, 11) == 0)
          drv_calm = !drv_calm;
        gap_left <= drv_calm ? 0 : $urandom_range(0, 5);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result back-pressure: after each taken beat a random stall, again with
  // calm stretches.
  // ---------------------------------------------------------------------------
  int unsigned hold_left = 0;
  bit          rcv_calm  = 1'b0;

  always @(negedge clk) begin : result_stall
    int unsigned n;
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (out_beat) begin
      if ($urandom_range(0, 11) == 0)
        rcv_calm = !rcv_calm;
      n = rcv_calm ? 0 : $urandom_range(0, 5);
      out_stall <= (n != 0);
      hold_left <= (n == 0) ? 0 : n - 1;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic queue_request(logic kind, logic [31:0] key, logic [31:0] value);
    pending_q.push_back(cache_request_t'{kind, key, value});
  endtask

  // Sender holds off until every predicted result has come back, then lets the
  // clock run on idle before anything touches the capacity register.
  task automatic wait_drained();
    do
      @(posedge clk);
    while (pending_q.size() != 0 || in_valid || results_owed != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CAP_BITS-1:0] c);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= c;
    do
      @(negedge clk);
    while (!cfg_beat);
    cfg_valid <= 1'b0;
  endtask

  // Mostly keys from a small pool so that hits, promotions and evictions
  // all happen; the rest fully random keys and the key extremes.
  task automatic run_random_phase(logic [CAP_BITS-1:0] c, int n_items, int pool_size);
    logic [31:0] pool[$];
    logic [31:0] key, value;
    int unsigned pick;
    write_capacity(c);
    for (int i = 0; i < pool_size; i++)
      pool.push_back($urandom);
    for (int i = 0; i < n_items; i++) begin
      pick = $urandom_range(0, 19);
      if (pick < 17)
        key = pool[$urandom_range(0, pool_size - 1)];
      else if (pick < 19)
        key = $urandom;
      else
        key = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
      case ($urandom_range(0, 15))
        0:       value = 32'h8000_0000;
        1:       value = 32'h7FFF_FFFF;
        2:       value = 32'hFFFF_FFFF;
        default: value = $urandom;
      endcase
      queue_request($urandom_range(0, 1) ? lkv_pkg::KIND_LOOKUP : lkv_pkg::KIND_INSERT,
                    key, value);
    end
    wait_drained();
  endtask

  initial begin : stimulus
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Capacity 0 acts as a single entry. Lookup on the empty store first.
    write_capacity(5'd0);
    queue_request(lkv_pkg::KIND_LOOKUP, 32'h0,         32'h0);
    queue_request(lkv_pkg::KIND_INSERT, 32'h0,         32'h8000_0000);
    queue_request(lkv_pkg::KIND_LOOKUP, 32'h0,         32'h1234_5678);
    queue_request(lkv_pkg::KIND_INSERT, 32'hFFFF_FFFF, 32'h7FFF_FFFF);  // replaces key 0
    queue_request(lkv_pkg::KIND_LOOKUP, 32'h0,         32'h0);          // now a miss
    queue_request(lkv_pkg::KIND_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);  // value ignored
    queue_request(lkv_pkg::KIND_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);  // overwrite in place
    wait_drained();

    // Three entries: fill, promote the oldest, evict, overwrite.
    write_capacity(5'd3);
    queue_request(lkv_pkg::KIND_INSERT, 32'h1,         32'h0);
    queue_request(lkv_pkg::KIND_INSERT, 32'h2,         32'h1);
    queue_request(lkv_pkg::KIND_LOOKUP, 32'hFFFF_FFFF, 32'h0);
    queue_request(lkv_pkg::KIND_INSERT, 32'h3,         32'h2);          // evicts key 1
    queue_request(lkv_pkg::KIND_LOOKUP, 32'h1,         32'h0);
    queue_request(lkv_pkg::KIND_LOOKUP, 32'h2,         32'h0);
    queue_request(lkv_pkg::KIND_INSERT, 32'h2,         32'h5);
    queue_request(lkv_pkg::KIND_INSERT, 32'h3,         32'hDEAD_BEEF);
    queue_request(lkv_pkg::KIND_LOOKUP, 32'h1234_5678, 32'h0);          // miss, no change
    wait_drained();

    run_random_phase(5'd2,  120, 5);
    run_random_phase(5'd1,  100, 3);    // capacity below the fill level
    run_random_phase(5'd31, 170, 24);   // saturates to the array size
    run_random_phase(5'd8,  120, 12);
    run_random_phase(5'd16, 140, 20);
    run_random_phase(5'd20, 110, 40);
    run_random_phase(CAP_BITS'($urandom_range(0, 31)), 120, $urandom_range(2, 30));

    repeat (8) @(posedge clk);

    $display("Run covered %0d requests: %0d lookups, %0d hits, %0d evictions,",
             n_requests, n_lookups, n_hits, n_evictions);
    $display("over %0d capacity writes, random gaps and result stalls on both sides.",
             n_cap_writes);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: files.f
src/lkv_pkg.sv
src/lkv_entry.sv
src/lru_key_value_cache_unit.sv
tb/lru_key_value_cache_unit_tb.sv
